[sv/tdc_pkg.sv]
// ----------------------------------------------------------------------------
// tdc_pkg
// Types and constants shared by the touch dimmer controller modules.
// ----------------------------------------------------------------------------
package tdc_pkg;

    localparam int CNT_W   = 10;
    localparam int LEVEL_W = 8;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 10;

    // Phase codes of the touch handling sequencer.
    localparam logic [2:0] PH_IDLE     = 3'd0;
    localparam logic [2:0] PH_ONDELAY  = 3'd1;
    localparam logic [2:0] PH_DEBOUNCE = 3'd2;
    localparam logic [2:0] PH_HOLD     = 3'd3;
    localparam logic [2:0] PH_RAMP     = 3'd4;
    localparam logic [2:0] PH_RELEASE  = 3'd5;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HOLD     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ON_DELAY = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_RAMP     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_MIN      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_MAX      = 3'd5;

    typedef struct packed {
        logic [CNT_W-1:0]   debounce_ticks;
        logic [CNT_W-1:0]   hold_ticks;
        logic [CNT_W-1:0]   on_delay_ticks;
        logic [7:0]         ramp_ticks;
        logic [LEVEL_W-1:0] min_brightness;
        logic [LEVEL_W-1:0] max_brightness;
    } t_cfg;

    typedef struct packed {
        logic               lamp_enabled;
        logic [LEVEL_W-1:0] brightness_level;
        logic               brightness_changed;
        logic               ramp_up_next;
        logic               leave_battery_mode;
        logic               busy_res;
    } t_result;

endpackage

[sv/touch_dimmer_controller_top.sv]
// ----------------------------------------------------------------------------
// touch_dimmer_controller_top
// Touch-pad lamp switch and dimmer, one item per millisecond tick.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_stall) carries one tick item: the pad
//   level and the battery-mode flag. Output channel (o_out_valid /
//   i_out_stall) returns exactly one result item per tick item: lamp enable,
//   brightness, step pulse, next ramp direction, battery-mode exit pulse and
//   busy flag, all as they stand after that tick.
//   The configuration channel (i_cfg_valid / o_cfg_ready) writes a register
//   by index; it is always ready and is meant to be used while idle.
//   Throughput is one item per cycle unless the input stalls, set by the
//   sequencer update in the core. When the receiver stalls, a skid stage
//   holds one more result; the input stalls only once both the result
//   register and the skid stage are full. o_out_valid comes from a register.
//   Reset (synchronous, active low) puts the sequencer idle, the lamp off,
//   brightness at 255, dimming down first, and all registers at defaults.
// ----------------------------------------------------------------------------
module touch_dimmer_controller_top
    import tdc_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic                  i_pad_touched,
    input  logic                  i_battery_mode_active,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic                  o_lamp_enabled,
    output logic [LEVEL_W-1:0]    o_brightness_level,
    output logic                  o_brightness_changed,
    output logic                  o_ramp_up_next,
    output logic                  o_leave_battery_mode,
    output logic                  o_busy_res,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_cfg    w_cfg;
    t_result w_res_next;
    t_result w_res_out;
    logic    w_full;
    logic    w_accept;

    assign o_in_stall = w_full;
    assign w_accept   = i_in_valid & ~w_full;

    tdc_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (w_cfg)
    );

    tdc_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (w_accept),
        .i_pad    (i_pad_touched),
        .i_bat    (i_battery_mode_active),
        .i_cfg    (w_cfg),
        .o_res    (w_res_next)
    );

    tdc_out_skid u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_accept),
        .i_res   (w_res_next),
        .o_full  (w_full),
        .o_valid (o_out_valid),
        .i_stall (i_out_stall),
        .o_res   (w_res_out)
    );

    assign o_lamp_enabled       = w_res_out.lamp_enabled;
    assign o_brightness_level   = w_res_out.brightness_level;
    assign o_brightness_changed = w_res_out.brightness_changed;
    assign o_ramp_up_next       = w_res_out.ramp_up_next;
    assign o_leave_battery_mode = w_res_out.leave_battery_mode;
    assign o_busy_res           = w_res_out.busy_res;

endmodule

[sv/tdc_cfg_regs.sv]
// ----------------------------------------------------------------------------
// tdc_cfg_regs
// Configuration register file, written through a valid/ready channel.
// ----------------------------------------------------------------------------
module tdc_cfg_regs
    import tdc_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output t_cfg                  o_cfg
);

    t_cfg r_cfg;
    logic w_wr;

    assign o_cfg_ready = 1'b1;
    assign w_wr        = i_cfg_valid;
    assign o_cfg       = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.debounce_ticks <= 10'd20;
            r_cfg.hold_ticks     <= 10'd200;
            r_cfg.on_delay_ticks <= 10'd200;
            r_cfg.ramp_ticks     <= 8'd2;
            r_cfg.min_brightness <= 8'd30;
            r_cfg.max_brightness <= 8'd255;
        end else if (w_wr) begin
            case (i_cfg_index)
                REG_DEBOUNCE: r_cfg.debounce_ticks <= i_cfg_data;
                REG_HOLD:     r_cfg.hold_ticks     <= i_cfg_data;
                REG_ON_DELAY: r_cfg.on_delay_ticks <= i_cfg_data;
                REG_RAMP:     r_cfg.ramp_ticks     <= i_cfg_data[7:0];
                REG_MIN:      r_cfg.min_brightness <= i_cfg_data[7:0];
                REG_MAX:      r_cfg.max_brightness <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

endmodule

[sv/tdc_core.sv]
// ----------------------------------------------------------------------------
// tdc_core
// Touch sequencer state and its per-tick next-state logic.
// ----------------------------------------------------------------------------
module tdc_core
    import tdc_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_accept,
    input  logic    i_pad,
    input  logic    i_bat,
    input  t_cfg    i_cfg,
    output t_result o_res
);

    logic [2:0]         r_phase, n_phase;
    logic [CNT_W-1:0]   r_cnt, n_cnt;
    logic               r_prev_pad;
    logic               r_lamp, n_lamp;
    logic [LEVEL_W-1:0] r_level, n_level;
    logic               r_ramp_up, n_ramp_up;
    logic               w_changed, w_leave;

    always_comb begin
        logic [CNT_W-1:0] cnt_inc;
        logic             edge_det;
        logic             room;
        logic             do_check;

        n_phase   = r_phase;
        n_cnt     = r_cnt;
        n_lamp    = r_lamp;
        n_level   = r_level;
        n_ramp_up = r_ramp_up;
        w_changed = 1'b0;
        w_leave   = 1'b0;
        do_check  = 1'b0;
        cnt_inc   = r_cnt + 10'd1;
        edge_det  = i_pad & ~r_prev_pad;
        room      = r_ramp_up ? (r_level < i_cfg.max_brightness)
                              : (r_level > i_cfg.min_brightness);

        case (r_phase)
            PH_IDLE: begin
                if (edge_det) begin
                    n_cnt = '0;
                    if (r_lamp) begin
                        n_phase = PH_DEBOUNCE;
                    end else if (i_cfg.on_delay_ticks == '0) begin
                        n_lamp = 1'b1;
                    end else begin
                        n_phase = PH_ONDELAY;
                    end
                end
            end
            PH_ONDELAY: begin
                n_cnt = cnt_inc;
                if (cnt_inc >= i_cfg.on_delay_ticks) begin
                    n_lamp  = 1'b1;
                    n_phase = PH_IDLE;
                    n_cnt   = '0;
                end
            end
            PH_DEBOUNCE: begin
                n_cnt = cnt_inc;
                if (cnt_inc >= i_cfg.debounce_ticks) begin
                    n_cnt   = '0;
                    n_phase = i_pad ? PH_HOLD : PH_IDLE;
                end
            end
            PH_HOLD: begin
                n_cnt = cnt_inc;
                if (cnt_inc >= i_cfg.hold_ticks) begin
                    n_cnt = '0;
                    if (i_pad) begin
                        do_check = 1'b1;
                    end else begin
                        if (i_bat) begin
                            w_leave = 1'b1;
                        end else begin
                            n_lamp = 1'b0;
                        end
                        n_phase = PH_IDLE;
                    end
                end
            end
            PH_RAMP: begin
                n_cnt = cnt_inc;
                if (cnt_inc >= {2'b00, i_cfg.ramp_ticks}) begin
                    do_check = 1'b1;
                end
            end
            PH_RELEASE: begin
                if (!i_pad) begin
                    n_phase = PH_IDLE;
                    n_cnt   = '0;
                end
            end
            default: begin
                n_phase = PH_IDLE;
                n_cnt   = '0;
            end
        endcase

        // A ramp check steps the level while the pad is held and the level
        // is inside its limit; otherwise the direction flips and the ramp ends.
        if (do_check) begin
            n_cnt = '0;
            if (i_pad && room) begin
                n_level   = r_ramp_up ? (r_level + 8'd1) : (r_level - 8'd1);
                n_phase   = PH_RAMP;
                w_changed = 1'b1;
            end else begin
                n_ramp_up = ~r_ramp_up;
                n_phase   = i_pad ? PH_RELEASE : PH_IDLE;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_IDLE;
            r_cnt      <= '0;
            r_prev_pad <= 1'b0;
            r_lamp     <= 1'b0;
            r_level    <= 8'd255;
            r_ramp_up  <= 1'b0;
        end else if (i_accept) begin
            r_phase    <= n_phase;
            r_cnt      <= n_cnt;
            r_prev_pad <= i_pad;
            r_lamp     <= n_lamp;
            r_level    <= n_level;
            r_ramp_up  <= n_ramp_up;
        end
    end

    assign o_res.lamp_enabled       = n_lamp;
    assign o_res.brightness_level   = n_level;
    assign o_res.brightness_changed = w_changed;
    assign o_res.ramp_up_next       = n_ramp_up;
    assign o_res.leave_battery_mode = w_leave;
    assign o_res.busy_res           = (n_phase != PH_IDLE);

endmodule

[sv/tdc_out_skid.sv]
// ----------------------------------------------------------------------------
// tdc_out_skid
// Result register with a skid stage, so a stalled receiver never loses an item.
// ----------------------------------------------------------------------------
module tdc_out_skid
    import tdc_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_result i_res,
    output logic    o_full,
    output logic    o_valid,
    input  logic    i_stall,
    output t_result o_res
);

    logic    r_out_valid;
    logic    r_skd_valid;
    t_result r_out;
    t_result r_skd;
    logic    w_pop;

    assign w_pop   = r_out_valid & ~i_stall;
    assign o_full  = r_skd_valid;
    assign o_valid = r_out_valid;
    assign o_res   = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_skd_valid <= 1'b0;
        end else begin
            if (!r_out_valid || w_pop) begin
                r_out_valid <= r_skd_valid | i_push;
                r_skd_valid <= 1'b0;
            end else if (i_push) begin
                r_skd_valid <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_valid || w_pop) begin
            r_out <= r_skd_valid ? r_skd : i_res;
        end
        if (i_push && !r_skd_valid) begin
            r_skd <= i_res;
        end
    end

endmodule

[dv/tdc_lamp_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tdc_lamp_checker
// Watches the tick, result and register channels of the touch dimmer
// controller, predicts the lamp status for every accepted tick item and
// compares each accepted result item with the oldest prediction.
// ----------------------------------------------------------------------------
module tdc_lamp_checker
    import tdc_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    input  logic                  i_in_stall,
    input  logic                  i_pad_touched,
    input  logic                  i_battery_mode_active,
    input  logic                  i_out_valid,
    input  logic                  i_out_stall,
    input  logic                  i_lamp_enabled,
    input  logic [LEVEL_W-1:0]    i_brightness_level,
    input  logic                  i_brightness_changed,
    input  logic                  i_ramp_up_next,
    input  logic                  i_leave_battery_mode,
    input  logic                  i_busy_res,
    input  logic                  i_cfg_valid,
    input  logic                  i_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output int                    o_fail_count,
    output int                    o_pending,
    output int                    o_checked,
    output int                    o_steps,
    output int                    o_leaves
);

    localparam int DEF_DEBOUNCE = 20;
    localparam int DEF_HOLD     = 200;
    localparam int DEF_ON_DELAY = 200;
    localparam int DEF_RAMP     = 2;
    localparam int DEF_MIN      = 30;
    localparam int DEF_MAX      = 255;

    t_cfg               cfg;
    logic [2:0]         phase;
    logic [CNT_W-1:0]   ticks;
    logic               prev_pad;
    logic               lamp_on;
    logic [LEVEL_W-1:0] level;
    logic               ramp_up;
    t_result            expected_status_q[$];

    int fail_total    = 0;
    int pending_total = 0;
    int checked_total = 0;
    int step_total    = 0;
    int leave_total   = 0;

    assign o_fail_count = fail_total;
    assign o_pending    = pending_total;
    assign o_checked    = checked_total;
    assign o_steps      = step_total;
    assign o_leaves     = leave_total;

    // One ramp decision: step the level if the pad is held and there is room,
    // otherwise turn the direction around and leave the ramp.
    function automatic logic try_ramp_step(input logic pad);
        logic room;
        room  = ramp_up ? (level < cfg.max_brightness) : (level > cfg.min_brightness);
        ticks = '0;
        if (pad && room) begin
            level = ramp_up ? level + 1'b1 : level - 1'b1;
            phase = PH_RAMP;
            return 1'b1;
        end
        ramp_up = ~ramp_up;
        phase   = pad ? PH_RELEASE : PH_IDLE;
        return 1'b0;
    endfunction

    task automatic advance_tick(input logic pad, input logic bat, output t_result status);
        logic touch_edge;
        logic changed;
        logic leave;
        touch_edge = pad && !prev_pad;
        changed    = 1'b0;
        leave      = 1'b0;
        case (phase)
            PH_IDLE: begin
                if (touch_edge) begin
                    ticks = '0;
                    if (lamp_on)
                        phase = PH_DEBOUNCE;
                    else if (cfg.on_delay_ticks == '0)
                        lamp_on = 1'b1;
                    else
                        phase = PH_ONDELAY;
                end
            end
            PH_ONDELAY: begin
                ticks = ticks + 1'b1;
                if (ticks >= cfg.on_delay_ticks) begin
                    lamp_on = 1'b1;
                    phase   = PH_IDLE;
                    ticks   = '0;
                end
            end
            PH_DEBOUNCE: begin
                ticks = ticks + 1'b1;
                if (ticks >= cfg.debounce_ticks) begin
                    ticks = '0;
                    phase = pad ? PH_HOLD : PH_IDLE;
                end
            end
            PH_HOLD: begin
                ticks = ticks + 1'b1;
                if (ticks >= cfg.hold_ticks) begin
                    ticks = '0;
                    if (pad) begin
                        changed = try_ramp_step(pad);
                    end else begin
                        // A short touch first cancels battery mode, if any.
                        if (bat)
                            leave = 1'b1;
                        else
                            lamp_on = 1'b0;
                        phase = PH_IDLE;
                    end
                end
            end
            PH_RAMP: begin
                ticks = ticks + 1'b1;
                if (ticks >= {2'b00, cfg.ramp_ticks})
                    changed = try_ramp_step(pad);
            end
            PH_RELEASE: begin
                if (!pad) begin
                    phase = PH_IDLE;
                    ticks = '0;
                end
            end
            default: begin
                phase = PH_IDLE;
                ticks = '0;
            end
        endcase
        prev_pad = pad;

        status.lamp_enabled       = lamp_on;
        status.brightness_level   = level;
        status.brightness_changed = changed;
        status.ramp_up_next       = ramp_up;
        status.leave_battery_mode = leave;
        status.busy_res           = (phase != PH_IDLE);
    endtask

    task automatic check_field(input string field, input logic [7:0] want,
                               input logic [7:0] got);
        if (got !== want) begin
            $error("%s mismatch: expected %0d, got %0d", field, want, got);
            fail_total++;
        end
    endtask

    always @(posedge i_clk) begin
        t_result want;
        t_result fresh;
        if (!i_rst_n) begin
            cfg.debounce_ticks = CNT_W'(DEF_DEBOUNCE);
            cfg.hold_ticks     = CNT_W'(DEF_HOLD);
            cfg.on_delay_ticks = CNT_W'(DEF_ON_DELAY);
            cfg.ramp_ticks     = 8'(DEF_RAMP);
            cfg.min_brightness = LEVEL_W'(DEF_MIN);
            cfg.max_brightness = LEVEL_W'(DEF_MAX);
            phase    = PH_IDLE;
            ticks    = '0;
            prev_pad = 1'b0;
            lamp_on  = 1'b0;
            level    = '1;
            ramp_up  = 1'b0;
            expected_status_q.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    REG_DEBOUNCE: cfg.debounce_ticks = i_cfg_data;
                    REG_HOLD:     cfg.hold_ticks     = i_cfg_data;
                    REG_ON_DELAY: cfg.on_delay_ticks = i_cfg_data;
                    REG_RAMP:     cfg.ramp_ticks     = i_cfg_data[7:0];
                    REG_MIN:      cfg.min_brightness = i_cfg_data[LEVEL_W-1:0];
                    REG_MAX:      cfg.max_brightness = i_cfg_data[LEVEL_W-1:0];
                    default: ;
                endcase
            end

            // The result leaving now belongs to an earlier tick, so pop first.
            if (i_out_valid && !i_out_stall) begin
                if (expected_status_q.size() == 0) begin
                    $error("result item arrived with no tick item outstanding");
                    fail_total++;
                end else begin
                    want = expected_status_q.pop_front();
                    check_field("lamp_enabled", 8'(want.lamp_enabled),
                                8'(i_lamp_enabled));
                    check_field("brightness_level", want.brightness_level,
                                i_brightness_level);
                    check_field("brightness_changed", 8'(want.brightness_changed),
                                8'(i_brightness_changed));
                    check_field("ramp_up_next", 8'(want.ramp_up_next),
                                8'(i_ramp_up_next));
                    check_field("leave_battery_mode", 8'(want.leave_battery_mode),
                                8'(i_leave_battery_mode));
                    check_field("busy_res", 8'(want.busy_res), 8'(i_busy_res));
                    checked_total++;
                end
            end

            if (i_in_valid && !i_in_stall) begin
                advance_tick(i_pad_touched, i_battery_mode_active, fresh);
                expected_status_q.push_back(fresh);
                if (fresh.brightness_changed)
                    step_total++;
                if (fresh.leave_battery_mode)
                    leave_total++;
            end
        end
        pending_total = expected_status_q.size();
    end

endmodule

[dv/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the touch dimmer controller: directed touches
// first, then random touch gestures under a series of register settings and
// traffic patterns, with a separate checker predicting every result item.
// ----------------------------------------------------------------------------
module tb_top;
    import tdc_pkg::*;

    localparam int                   HALF_PERIOD    = 6;
    localparam int                   RESET_CYCLES   = 7;
    localparam int                   HOLDOFF_CYCLES = 64;
    localparam int                   WATCHDOG_LIMIT = 4000;
    localparam int                   FLUSH_CYCLES   = 6;
    localparam logic [CFG_IDX_W-1:0] SPARE_REG_A    = 3'd6;
    localparam logic [CFG_IDX_W-1:0] SPARE_REG_B    = 3'd7;

    logic                  clk                = 1'b0;
    logic                  rst_n              = 1'b0;
    logic                  in_valid           = 1'b0;
    logic                  in_stall;
    logic                  pad_touched        = 1'b0;
    logic                  battery_mode       = 1'b0;
    logic                  out_valid;
    logic                  out_stall          = 1'b0;
    logic                  lamp_enabled;
    logic [LEVEL_W-1:0]    brightness_level;
    logic                  brightness_changed;
    logic                  ramp_up_next;
    logic                  leave_battery_mode;
    logic                  busy_flag;
    logic                  cfg_valid          = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index          = '0;
    logic [CFG_DATA_W-1:0] cfg_data           = '0;

    int fail_count;
    int pending;
    int checked;
    int steps;
    int leaves;

    int   gap_pct          = 0;
    int   stall_pct        = 0;
    int   holdoff_reqs     = 0;
    int   holdoff_done     = 0;
    int   items_sent       = 0;
    int   cfg_writes       = 0;
    int   settings_applied = 0;
    t_cfg live_cfg;

    touch_dimmer_controller_top u_dut (
        .i_clk                 (clk),
        .i_rst_n               (rst_n),
        .i_in_valid            (in_valid),
        .o_in_stall            (in_stall),
        .i_pad_touched         (pad_touched),
        .i_battery_mode_active (battery_mode),
        .o_out_valid           (out_valid),
        .i_out_stall           (out_stall),
        .o_lamp_enabled        (lamp_enabled),
        .o_brightness_level    (brightness_level),
        .o_brightness_changed  (brightness_changed),
        .o_ramp_up_next        (ramp_up_next),
        .o_leave_battery_mode  (leave_battery_mode),
        .o_busy_res            (busy_flag),
        .i_cfg_valid           (cfg_valid),
        .o_cfg_ready           (cfg_ready),
        .i_cfg_index           (cfg_index),
        .i_cfg_data            (cfg_data)
    );

    tdc_lamp_checker u_checker (
        .i_clk                 (clk),
        .i_rst_n               (rst_n),
        .i_in_valid            (in_valid),
        .i_in_stall            (in_stall),
        .i_pad_touched         (pad_touched),
        .i_battery_mode_active (battery_mode),
        .i_out_valid           (out_valid),
        .i_out_stall           (out_stall),
        .i_lamp_enabled        (lamp_enabled),
        .i_brightness_level    (brightness_level),
        .i_brightness_changed  (brightness_changed),
        .i_ramp_up_next        (ramp_up_next),
        .i_leave_battery_mode  (leave_battery_mode),
        .i_busy_res            (busy_flag),
        .i_cfg_valid           (cfg_valid),
        .i_cfg_ready           (cfg_ready),
        .i_cfg_index           (cfg_index),
        .i_cfg_data            (cfg_data),
        .o_fail_count          (fail_count),
        .o_pending             (pending),
        .o_checked             (checked),
        .o_steps               (steps),
        .o_leaves              (leaves)
    );

    always #HALF_PERIOD clk = ~clk;

    // Result side: random stalls, or a long hold-off when one is requested.
    initial begin
        forever begin
            @(negedge clk);
            if (holdoff_reqs != holdoff_done) begin
                out_stall <= 1'b1;
                repeat (HOLDOFF_CYCLES - 1) @(negedge clk);
                holdoff_done++;
            end else begin
                out_stall <= ($urandom_range(99) < stall_pct);
            end
        end
    end

    initial begin
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge clk);
            if (rst_n && !((in_valid && !in_stall) || (out_valid && !out_stall) ||
                           (cfg_valid && cfg_ready)))
                quiet++;
            else
                quiet = 0;
        end
        $display("Watchdog: no handshake for %0d cycles", WATCHDOG_LIMIT);
        $display("Regression FAIL");
        $finish;
    end

    function automatic t_cfg make_cfg(input int deb, input int hld, input int ond,
                                      input int rmp, input int mn, input int mx);
        t_cfg c;
        c.debounce_ticks = CNT_W'(deb);
        c.hold_ticks     = CNT_W'(hld);
        c.on_delay_ticks = CNT_W'(ond);
        c.ramp_ticks     = 8'(rmp);
        c.min_brightness = LEVEL_W'(mn);
        c.max_brightness = LEVEL_W'(mx);
        return c;
    endfunction

    // Short timings keep gestures brief; the brightness window is narrow in
    // half of the settings so that ramps run into their limits.
    function automatic t_cfg rand_cfg();
        int mn;
        int mx;
        int pick;
        pick = $urandom_range(9);
        mn   = $urandom_range(255);
        mx   = $urandom_range(255);
        if (pick < 5) begin
            mx = mn + $urandom_range(15);
            if (mx > 255)
                mx = 255;
        end else if (pick == 7) begin
            mn = $urandom_range(255, 129);
            mx = $urandom_range(mn - 1);
        end else if (pick > 7) begin
            mn = 0;
            mx = 255;
        end
        return make_cfg($urandom_range(4), $urandom_range(8), $urandom_range(5),
                        $urandom_range(3), mn, mx);
    endfunction

    task automatic put_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        @(negedge clk);
        cfg_writes++;
    endtask

    // Called at a falling edge with nothing outstanding. Upper data bits of
    // the 8-bit registers are random and must be dropped by the block.
    task automatic apply_settings(input t_cfg c);
        live_cfg = c;
        settings_applied++;
        cfg_valid <= 1'b1;
        if ($urandom_range(1))
            put_reg($urandom_range(1) ? SPARE_REG_A : SPARE_REG_B, CFG_DATA_W'($urandom));
        put_reg(REG_DEBOUNCE, c.debounce_ticks);
        put_reg(REG_HOLD, c.hold_ticks);
        put_reg(REG_ON_DELAY, c.on_delay_ticks);
        put_reg(REG_RAMP, {2'($urandom_range(3)), c.ramp_ticks});
        put_reg(REG_MIN, {2'($urandom_range(3)), c.min_brightness});
        put_reg(REG_MAX, {2'($urandom_range(3)), c.max_brightness});
        cfg_valid <= 1'b0;
    endtask

    task automatic send_tick(input logic pad, input logic bat);
        while ($urandom_range(99) < gap_pct) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid     <= 1'b1;
        pad_touched  <= pad;
        battery_mode <= bat;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        @(negedge clk);
        items_sent++;
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        while (pending != 0) @(negedge clk);
    endtask

    task automatic play_bits(input logic [31:0] pads, input logic [31:0] bats,
                             input int count);
        for (int i = count - 1; i >= 0; i--)
            send_tick(pads[i], bats[i]);
    endtask

    task automatic touch(input int press_len, input int release_len);
        repeat (press_len) send_tick(1'b1, $urandom_range(2) == 0);
        repeat (release_len) send_tick(1'b0, $urandom_range(2) == 0);
    endtask

    task automatic run_phase(input int n_items, input bit squeeze);
        int stop_at;
        int deb;
        int hld;
        int rmp;
        int ond;
        int kind;
        int press;
        int rel;
        bit squeezed;
        stop_at  = items_sent + n_items;
        squeezed = 1'b0;
        deb = (live_cfg.debounce_ticks == 0) ? 1 : int'(live_cfg.debounce_ticks);
        hld = (live_cfg.hold_ticks == 0) ? 1 : int'(live_cfg.hold_ticks);
        rmp = (live_cfg.ramp_ticks == 0) ? 1 : int'(live_cfg.ramp_ticks);
        ond = int'(live_cfg.on_delay_ticks);
        while (items_sent < stop_at) begin
            // Hold the receiver off while ticks keep coming, to fill the block.
            if (squeeze && !squeezed && items_sent > stop_at - n_items / 2) begin
                holdoff_reqs++;
                squeezed = 1'b1;
            end
            kind = $urandom_range(99);
            if (kind < 70) begin
                press = $urandom_range(deb + hld + 1 + rmp * $urandom_range(16), 1);
                if (press > stop_at - items_sent)
                    press = stop_at - items_sent;
                rel = $urandom_range(ond + 2, 1);
                if (rel > stop_at - items_sent - press)
                    rel = stop_at - items_sent - press;
                if (rel < 1)
                    rel = 1;
                touch(press, rel);
            end else if (kind < 85) begin
                press = $urandom_range(deb, 1);
                if (press > stop_at - items_sent)
                    press = stop_at - items_sent;
                touch(press, 1);
            end else begin
                repeat ($urandom_range(6, 1))
                    send_tick($urandom_range(1), $urandom_range(1));
            end
        end
    endtask

    initial begin
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Zero periods: lamp on at the edge tick, battery exit, a ramp down to
        // the minimum, a release during debounce, then a short touch off.
        apply_settings(make_cfg(0, 0, 0, 0, 250, 255));
        play_bits(32'b01011011111111010110, 32'b00011100000000000000, 20);
        settle();
        // With an on-delay running, a further edge is ignored.
        apply_settings(make_cfg(0, 0, 2, 0, 250, 255));
        play_bits(32'b1011, 32'b0110, 4);

        settle();
        apply_settings(make_cfg(1023, 1023, 1023, 255, 255, 0));
        run_phase(40, 1'b0);

        settle();
        apply_settings(make_cfg(0, 0, 0, 0, 0, 255));
        run_phase(100, 1'b0);

        for (int p = 0; p < 8; p++) begin
            settle();
            apply_settings(rand_cfg());
            case (p % 4)
                0: begin gap_pct = 0;  stall_pct = 0;  end
                1: begin gap_pct = 73; stall_pct = 0;  end
                2: begin gap_pct = 0;  stall_pct = 73; end
                default: begin gap_pct = 14; stall_pct = 14; end
            endcase
            run_phase(120, p == 4);
        end

        settle();
        repeat (FLUSH_CYCLES) @(negedge clk);
        $display("Sent %0d tick items under %0d register settings (%0d register writes).",
                 items_sent, settings_applied, cfg_writes);
        $display("Checked %0d results, with %0d brightness steps and %0d battery exits.",
                 checked, steps, leaves);
        if (fail_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
